### sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg - shared definitions for the multi-stack shared pool
// Sizes, pointer widths, operation and status codes and the control states.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Sizing
  localparam int NUM_STACKS = 8;
  localparam int POOL_SIZE  = 256;
  localparam int DATA_WIDTH = 32;

  // Port widths fixed by the transaction format
  localparam int MODE_W     = 1;
  localparam int STACK_ID_W = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  // Derived widths: a pointer also holds the null value POOL_SIZE
  localparam int PTR_W = $clog2(POOL_SIZE + 1);
  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_SIZE);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
  localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### sv/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool - several LIFO stacks over one shared entry pool
// Linked stacks and a free list threaded through a link RAM and a data RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction is a push of
//   in_push_value onto stack in_stack_id (in_mode = 0) or a pop from it
//   (in_mode = 1). Result channel (out_valid / out_stall): one transaction
//   per input, carrying out_status (done, pool full, stack empty) and
//   out_pop_value (popped word, zero otherwise).
//   Result: the transaction is registered at acceptance; the result is
//   registered in the output register when execute finishes, which sets
//   out_valid. An accepted input reads the link and data RAMs at
//   the chosen entry in the idle state; the execute state writes links
//   and pointers back. The next input is held off until that write is done.
//   Reset: all stacks empty, free list runs 0,1,2,... through the pool. The
//   link RAM needs no clearing pass: entries at or above the fill mark have
//   never been written and read as "next entry" by construction.
//   Stall: a finished result waits in the output register; a new input is
//   still taken, and its write-back holds until the waiting result leaves.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool
  import msp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [STACK_ID_W-1:0]      in_stack_id,
  input  logic signed [VALUE_W-1:0]  in_push_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_pop_value
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic in_accept;
  logic exec_fin;

  // Transaction captured at acceptance
  logic [MODE_W-1:0]     mode_r;
  logic [SID_W-1:0]      sid_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [PTR_W-1:0]      slot_r;
  logic                  ok_r;     // operation will go ahead
  logic                  fresh_r;  // slot has never been written in link RAM

  // Pointer state
  logic [PTR_W-1:0] stack_top_r [NUM_STACKS];
  logic [PTR_W-1:0] free_head_r;
  logic [PTR_W-1:0] fill_r;        // entries below this have been written

  // Output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_pop_value_r;

  // Acceptance-side decode
  logic [SID_W-1:0]      in_sid;
  logic                  in_sid_ok;
  logic [PTR_W-1:0]      in_top;
  logic [PTR_W-1:0]      slot_nxt;
  logic                  ok_nxt;

  // Execute-side decode
  logic [PTR_W-1:0]      link_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [PTR_W-1:0]      link_cur;
  logic [PTR_W-1:0]      link_next;
  logic [PTR_W-1:0]      top_cur;
  logic                  do_write;
  logic                  do_push;
  logic [PTR_W-1:0]      link_wdata;

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM: outputs. Hold the write-back while a result still waits downstream.
  always_comb begin
    in_stall = 1'b1;
    exec_fin = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EXEC: begin
        exec_fin = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Acceptance: pick the entry to touch and decide refusal up front
  // --------------------------------------------------------------------------
  assign in_sid    = SID_W'(in_stack_id);
  assign in_sid_ok = int'(in_stack_id) < NUM_STACKS;
  assign in_top    = stack_top_r[in_sid];

  always_comb begin
    if (in_mode == MODE_PUSH) begin
      slot_nxt = free_head_r;
      ok_nxt   = in_sid_ok && (free_head_r != NIL_PTR);
    end else begin
      slot_nxt = in_top;
      ok_nxt   = in_sid_ok && (in_top != NIL_PTR);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r  <= in_mode;
      sid_r   <= in_sid;
      value_r <= DATA_WIDTH'($unsigned(in_push_value));
      slot_r  <= slot_nxt;
      ok_r    <= ok_nxt;
      fresh_r <= slot_nxt >= fill_r;
    end
  end

  // --------------------------------------------------------------------------
  // Pool memories: read at acceptance, written back at the end of execute
  // --------------------------------------------------------------------------
  assign do_write = exec_fin && ok_r;
  assign do_push  = do_write && (mode_r == MODE_PUSH);

  msp_ram #(
    .WIDTH (PTR_W),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (slot_r[IDX_W-1:0]),
    .wr_data (link_wdata),
    .rd_en   (in_accept),
    .rd_addr (slot_nxt[IDX_W-1:0]),
    .rd_data (link_q)
  );

  msp_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (POOL_SIZE)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (slot_r[IDX_W-1:0]),
    .wr_data (value_r),
    .rd_en   (in_accept),
    .rd_addr (slot_nxt[IDX_W-1:0]),
    .rd_data (data_q)
  );

  // --------------------------------------------------------------------------
  // Execute: relink and update pointers
  // --------------------------------------------------------------------------
  // An entry never written still carries its reset link: the next entry,
  // which for the last entry is the null pointer itself.
  assign link_cur  = fresh_r ? (slot_r + PTR_W'(1)) : link_q;
  // Treat any out-of-range link as null
  assign link_next = (link_cur < NIL_PTR) ? link_cur : NIL_PTR;
  assign top_cur   = stack_top_r[sid_r];

  // Push links the new entry to the old top; pop returns it to the free list
  assign link_wdata = (mode_r == MODE_PUSH) ? top_cur : free_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top_r[i] <= NIL_PTR;
      end
    end else begin
      state_r <= state_nxt;
      if (do_write) begin
        if (mode_r == MODE_PUSH) begin
          free_head_r        <= link_next;
          stack_top_r[sid_r] <= slot_r;
          if (fresh_r) begin
            fill_r <= fill_r + PTR_W'(1);
          end
        end else begin
          stack_top_r[sid_r] <= link_next;
          free_head_r        <= slot_r;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fin) begin
      if (ok_r) begin
        out_status_r <= STATUS_DONE;
      end else if (mode_r == MODE_PUSH) begin
        out_status_r <= STATUS_FULL;
      end else begin
        out_status_r <= STATUS_EMPTY;
      end
      if (ok_r && (mode_r == MODE_POP)) begin
        out_pop_value_r <= VALUE_W'(data_q);
      end else begin
        out_pop_value_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = signed'(out_pop_value_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted transaction always moves on to the write-back cycle
  a_accept_exec : assert property (
    @(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC)
  ) else $error("accepted transaction did not enter execute");

  // The free head is a recycled entry, the fill mark, or null
  a_free_head_fill : assert property (
    @(posedge clk) disable iff (!rst_n)
    (free_head_r <= fill_r) || (free_head_r == NIL_PTR)
  ) else $error("free head beyond fill mark");

  // A never-written entry is only ever taken exactly at the fill mark
  a_fresh_slot : assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && ok_r && fresh_r && mode_r == MODE_PUSH) |-> (slot_r == fill_r)
  ) else $error("fresh push slot differs from fill mark");

endmodule
